// ===== rtl/sha256_byte_stream_hasher_assert.svh =====
// Assertion macros shared by the SHA-256 byte stream hasher RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define SBH_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet in reset.
`define SBH_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sha_bsh_pkg.sv =====
// Shared types, constants and SHA-256 helper functions for the byte stream hasher.
// No dependencies; imported by every module of the block.
package sha_bsh_pkg;

   typedef logic [31:0] word_type;

   // Round constants of the compression function.
   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Initial hash value.
   localparam word_type HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_MARK        = 8'h80;
   localparam logic [5:0] LAST_ROUND      = 6'd63;
   localparam logic [5:0] LAST_BLOCK_BYTE = 6'd63;
   localparam logic [5:0] LENGTH_START    = 6'd56;
   localparam logic [2:0] LAST_DIGEST     = 3'd7;

   // Commands from the sequencer to the round unit.
   typedef struct packed {
      logic init;   // restore the initial hash value
      logic load;   // copy the hash into the working variables
      logic step;   // run one round
      logic add;    // fold the working variables into the hash
   } core_ctl_type;

   // Commands from the sequencer to the block window.
   typedef struct packed {
      logic       push;  // shift one byte in
      logic       step;  // advance the message schedule by one word
      logic [7:0] data;
   } sched_ctl_type;

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// ===== rtl/sha_bsh_sched.sv =====
// Block window: gathers message bytes into a 64-byte block and then serves
// the message schedule one word per round. Depends on sha_bsh_pkg.
module sha_bsh_sched
   import sha_bsh_pkg::*;
(
   input  logic          clock,
   input  sched_ctl_type ctl,
   output word_type      sched_word
);

   logic [511:0] window_ff, window_in;
   word_type     w0, w1, w9, w14, next_word;

   // Word j of the window sits at bits 511-32j down to 480-32j.
   assign w0  = window_ff[511:480];
   assign w1  = window_ff[479:448];
   assign w9  = window_ff[223:192];
   assign w14 = window_ff[63:32];

   // Schedule word sixteen places ahead of the one in use.
   assign next_word = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

   // Bytes enter at the bottom; rounds shift whole words out of the top.
   always_comb begin
      window_in = window_ff;
      if (ctl.push) begin
         window_in = {window_ff[503:0], ctl.data};
      end else if (ctl.step) begin
         window_in = {window_ff[479:0], next_word};
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   assign sched_word = w0;

endmodule

// ===== rtl/sha_bsh_core.sv =====
// Shared round unit: working variables, one compression round per cycle,
// and the eight-word hash state. Depends on sha_bsh_pkg.
module sha_bsh_core
   import sha_bsh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  core_ctl_type ctl,
   input  logic [5:0]   round_idx,
   input  word_type     sched_word,
   input  logic [2:0]   word_sel,
   output word_type     digest_word
);

   word_type hash_ff [8];
   word_type hash_in [8];
   word_type work_ff [8];
   word_type work_in [8];
   word_type t1, t2, choose, major;

   // One round of the compression function on a..h (indices 0..7).
   always_comb begin
      choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
               (work_ff[1] & work_ff[2]);
      t1 = work_ff[7] + big_sigma1(work_ff[4]) + choose + ROUND_K[round_idx] + sched_word;
      t2 = big_sigma0(work_ff[0]) + major;
   end

   // Working variables.
   always_comb begin
      work_in = work_ff;
      if (ctl.load) begin
         work_in = hash_ff;
      end else if (ctl.step) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
   end

   // Hash state: restored between messages, updated after each block.
   always_comb begin
      hash_in = hash_ff;
      if (ctl.init) begin
         hash_in = HASH_INIT;
      end else if (ctl.add) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (reset) begin
         hash_ff <= HASH_INIT;
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign digest_word = hash_ff[word_sel];

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: handshakes, padding and round sequencer.
// Depends on sha_bsh_pkg, sha_bsh_sched, sha_bsh_core and the assertion header.
//
// A message arrives one byte per transaction; a transaction with end_of_message set
// closes it (with or without a byte) and the digest leaves as eight 32-bit
// transactions, most significant word first, after which the block is ready for a
// new message. A byte that does not fill a block leaves it ready for the next byte.
// A byte that fills the 64-byte block is taken, then 64 rounds run through the single
// shared round unit and the result is folded into the hash. On the closing
// transaction the padding is shifted in one byte per cycle until the block is full,
// up to 72 padding bytes over two blocks; one block run follows, or two when fewer
// than nine bytes are free, each ending in the fold, and then the digest is sent.
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher
   import sha_bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FINAL = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [5:0]    bib_ff, bib_in;
   logic [60:0]   count_ff, count_in, count_next;
   logic [63:0]   length_ff, length_in;
   logic [5:0]    round_ff, round_in;
   logic [2:0]    word_ff, word_in;
   logic          closing_ff, closing_in;
   logic          first_ff, first_in;
   logic          len_ok_ff, len_ok_in;
   logic          req_accept, rsp_accept;
   core_ctl_type  core_ctl;
   sched_ctl_type sched_ctl;
   word_type      sched_word;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_OUT);
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;
   assign count_next = count_ff + 61'd1;

   // Sequencer: byte intake, padding, rounds and digest delivery.
   always_comb begin
      state_in   = state_ff;
      bib_in     = bib_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      round_in   = round_ff;
      word_in    = word_ff;
      closing_in = closing_ff;
      first_in   = first_ff;
      len_ok_in  = len_ok_ff;
      core_ctl   = '0;
      sched_ctl  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               length_in = req_byte_present ? {count_next, 3'b000} : {count_ff, 3'b000};
               if (req_byte_present) begin
                  sched_ctl.push = 1'b1;
                  sched_ctl.data = req_data_byte;
                  bib_in         = bib_ff + 6'd1;
                  count_in       = count_next;
               end
               if (req_byte_present && bib_ff == LAST_BLOCK_BYTE) begin
                  state_in      = ST_ROUND;
                  core_ctl.load = 1'b1;
                  round_in      = '0;
                  closing_in    = req_end_of_message;
                  first_in      = 1'b1;
               end else if (req_end_of_message) begin
                  state_in   = ST_PAD;
                  closing_in = 1'b1;
                  first_in   = 1'b1;
               end
            end
         end
         ST_PAD: begin
            sched_ctl.push = 1'b1;
            bib_in         = bib_ff + 6'd1;
            first_in       = 1'b0;
            if (first_ff) begin
               sched_ctl.data = PAD_MARK;
               len_ok_in      = (bib_ff < LENGTH_START);
            end else if (len_ok_ff && bib_ff >= LENGTH_START) begin
               sched_ctl.data = length_ff[63:56];
               length_in      = {length_ff[55:0], 8'h00};
            end else begin
               sched_ctl.data = 8'h00;
            end
            if (bib_ff == LAST_BLOCK_BYTE) begin
               state_in      = ST_ROUND;
               core_ctl.load = 1'b1;
               round_in      = '0;
            end
         end
         ST_ROUND: begin
            core_ctl.step  = 1'b1;
            sched_ctl.step = 1'b1;
            round_in       = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            core_ctl.add = 1'b1;
            if (!closing_ff) begin
               state_in = ST_IDLE;
            end else if (first_ff) begin
               state_in = ST_PAD;
            end else if (len_ok_ff) begin
               state_in = ST_OUT;
               word_in  = '0;
            end else begin
               state_in  = ST_PAD;
               len_ok_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_accept) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LAST_DIGEST) begin
                  state_in      = ST_IDLE;
                  core_ctl.init = 1'b1;
                  bib_in        = '0;
                  count_in      = '0;
                  closing_in    = 1'b0;
                  first_in      = 1'b0;
                  len_ok_in     = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      length_ff <= length_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         bib_ff     <= '0;
         count_ff   <= '0;
         round_ff   <= '0;
         word_ff    <= '0;
         closing_ff <= 1'b0;
         first_ff   <= 1'b0;
         len_ok_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bib_ff     <= bib_in;
         count_ff   <= count_in;
         round_ff   <= round_in;
         word_ff    <= word_in;
         closing_ff <= closing_in;
         first_ff   <= first_in;
         len_ok_ff  <= len_ok_in;
      end
   end

   sha_bsh_sched u_sched (
      .clock      (clock),
      .ctl        (sched_ctl),
      .sched_word (sched_word)
   );

   sha_bsh_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (core_ctl),
      .round_idx   (round_ff),
      .sched_word  (sched_word),
      .word_sel    (word_ff),
      .digest_word (rsp_digest_word)
   );

   assign rsp_word_index = word_ff;
   assign rsp_last_word  = (word_ff == LAST_DIGEST);

   // Checks on the sequencer.
   `SBH_ASSERT_IMP(a_out_blocks_in, rsp_valid, !req_ready, "digest shown while taking bytes")
   `SBH_ASSERT_IMP(a_round_entry, $rose(state_ff == ST_ROUND),
      bib_ff == '0 && round_ff == '0, "block run started on a partial block")
   `SBH_ASSERT_IMP(a_out_after_len, rsp_valid,
      len_ok_ff && !first_ff && bib_ff == '0, "digest shown before the length block ran")
   `SBH_ASSERT_NXT(a_digest_done, rsp_accept && rsp_last_word,
      req_ready && count_ff == '0 && bib_ff == '0, "state not cleared after the digest")

endmodule
